// ===== hw/rtl/tpit_pkg.sv =====
// Shared constants for the triangle pair crossing test.
`timescale 1ns / 1ps
package tpit_pkg;

   localparam int COORD_BITS_DEF = 21;
   localparam int FRAC_BITS_DEF  = 16;

   localparam int FIELD_BITS    = 63;
   localparam int NUM_FIELDS    = 6;
   localparam int REQ_DATA_BITS = 384;
   localparam int RSP_DATA_BITS = 8;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int TOL_BITS      = 16;
   localparam logic REG_TOLERANCE = 1'b0;

   localparam int MUL_CHUNK = 24;
   localparam int LANES     = 4;

endpackage

// ===== hw/rtl/tpit_mul.sv =====
// Two-stage signed multiplier built from registered chunk products.
`timescale 1ns / 1ps
module tpit_mul import tpit_pkg::*; #(
   parameter int AW = 45,
   parameter int BW = 45
) (
   input  logic                      clock,
   input  logic                      en,
   input  logic signed [AW-1:0]      a,
   input  logic signed [BW-1:0]      b,
   output logic signed [AW+BW-1:0]   prod
);

   localparam int CH = MUL_CHUNK;
   localparam int NA = (AW + CH - 1) / CH;
   localparam int NB = (BW + CH - 1) / CH;
   localparam int PW = AW + BW;

   logic signed [NA*CH-1:0]  ax;
   logic signed [NB*CH-1:0]  bx;
   logic signed [CH:0]       ac [NA];
   logic signed [CH:0]       bc [NB];
   logic signed [2*CH+1:0]   pp_in [NA][NB];
   logic signed [2*CH+1:0]   pp_ff [NA][NB];
   logic signed [PW-1:0]     acc_in;
   logic signed [PW-1:0]     acc_ff;

   assign ax = (NA*CH)'(a);
   assign bx = (NB*CH)'(b);

   always_comb begin
      for (int i = 0; i < NA; i++) begin
         if (i == NA - 1) ac[i] = {ax[i*CH+CH-1], ax[i*CH +: CH]};
         else             ac[i] = {1'b0, ax[i*CH +: CH]};
      end
      for (int j = 0; j < NB; j++) begin
         if (j == NB - 1) bc[j] = {bx[j*CH+CH-1], bx[j*CH +: CH]};
         else             bc[j] = {1'b0, bx[j*CH +: CH]};
      end
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            pp_in[i][j] = ac[i] * bc[j];
         end
      end
   end

   always_comb begin
      acc_in = '0;
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            acc_in = acc_in + (PW'(pp_ff[i][j]) <<< (CH * (i + j)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp_ff  <= pp_in;
         acc_ff <= acc_in;
      end
   end

   assign prod = acc_ff;

endmodule

// ===== hw/rtl/tpit_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a side payload.
`timescale 1ns / 1ps
module tpit_div import tpit_pkg::*; #(
   parameter int DW = 70,
   parameter int QW = 17,
   parameter int PW = 8
) (
   input  logic            clock,
   input  logic            en,
   input  logic [DW-1:0]   num [LANES],
   input  logic [DW-1:0]   den [LANES],
   input  logic [PW-1:0]   pay_src,
   output logic [QW-1:0]   quo [LANES],
   output logic [PW-1:0]   pay_dst
);

   logic [DW-1:0] rem_ff [QW][LANES];
   logic [DW-1:0] rem_in [QW][LANES];
   logic [DW-1:0] dvs_ff [QW][LANES];
   logic [DW-1:0] dvs_in [QW][LANES];
   logic [QW-1:0] q_ff   [QW][LANES];
   logic [QW-1:0] q_in   [QW][LANES];
   logic [PW-1:0] pay_ff [QW];
   logic [PW-1:0] pay_in [QW];

   always_comb begin
      logic [DW-1:0] rs;
      logic [DW-1:0] ds;
      logic [QW-1:0] qs;
      logic [DW:0]   sh;
      logic          ge;
      for (int s = 0; s < QW; s++) begin
         if (s == 0) pay_in[s] = pay_src;
         else        pay_in[s] = pay_ff[s-1];
         for (int l = 0; l < LANES; l++) begin
            if (s == 0) begin
               rs = num[l];
               ds = den[l];
               qs = '0;
               sh = {1'b0, rs};
            end else begin
               rs = rem_ff[s-1][l];
               ds = dvs_ff[s-1][l];
               qs = q_ff[s-1][l];
               sh = {rs, 1'b0};
            end
            ge = sh >= {1'b0, ds};
            rem_in[s][l] = ge ? DW'(sh - {1'b0, ds}) : DW'(sh);
            dvs_in[s][l] = ds;
            q_in[s][l]   = qs | (ge ? (QW'(1) << (QW - 1 - s)) : QW'(0));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         dvs_ff <= dvs_in;
         q_ff   <= q_in;
         pay_ff <= pay_in;
      end
   end

   assign quo     = q_ff[QW-1];
   assign pay_dst = pay_ff[QW-1];

endmodule

// ===== hw/rtl/triangle_pair_intersection_test.sv =====
// Top level of the triangle pair crossing test pipeline.
//
// Channel   Dir   Handshake              Payload
// req_      in    req_tvalid/req_tready  six packed vertices, 63 bits each
// rsp_      out   rsp_tvalid/rsp_tready  crossing flag
// csr_      in    APB write/read         theta_tolerance at byte address 0
//
// One pair enters per cycle while no stalled result holds the pipe.
// The per-bit quotient stages of the crossing fraction make up most of the pipeline depth.
// All stages advance together; a stalled result holds the whole pipe.
// Reset clears the valid line and the tolerance register.
`timescale 1ns / 1ps
module triangle_pair_intersection_test import tpit_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // first_vertex_a, first_vertex_b, first_vertex_c,
   // second_vertex_a, second_vertex_b, second_vertex_c
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // crossing
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                      csr_pready
);

   localparam int C     = COORD_BITS;
   localparam int EW    = C + 1;
   localparam int PEW   = 2 * EW;
   localparam int NW    = PEW + 1;
   localparam int RW    = 2 * NW + 1;
   localparam int SW    = NW + EW + 2;
   localparam int XW    = RW + C + 2;
   localparam int XD    = XW + 1;
   localparam int DW    = SW + 1;
   localparam int QW    = FRAC_BITS + 1;
   localparam int TW    = XW + FRAC_BITS + 4;
   localparam int SNW   = FRAC_BITS + TOL_BITS + 1;
   localparam int DEPTH = FRAC_BITS + 16;

   typedef struct packed {
      logic [1:0][2:0]    below;
      logic [1:0][2:0]    above;
      logic [1:0][1:0]    lone;
      logic [1:0][DW-1:0] rem;
      logic [3:0][DW-1:0] den;
   } cls_type;

   typedef struct packed {
      logic [1:0][2:0]    below;
      logic [1:0][2:0]    above;
      logic [1:0][1:0]    lone;
      logic [1:0][XW-1:0] xpl;
      logic [3:0][XD-1:0] xdiff;
   } side_type;

   function automatic int nxt(input int c);
      return (c == 2) ? 0 : c + 1;
   endfunction

   function automatic int prv(input int c);
      return (c == 0) ? 2 : c - 1;
   endfunction

   function automatic logic [1:0] oth_of(input logic [1:0] ln, input logic sel);
      logic [1:0] o0;
      o0 = (ln == 2'd2) ? 2'd0 : ln + 2'd1;
      return sel ? 2'd3 - ln - o0 : o0;
   endfunction

   // configuration
   logic [TOL_BITS-1:0] tol_ff;
   logic                csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= '0;
      end else if (csr_wr && csr_paddr[CSR_ADDR_BITS-1] == REG_TOLERANCE) begin
         tol_ff <= csr_pwdata[TOL_BITS-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[CSR_ADDR_BITS-1] == REG_TOLERANCE) ?
                       CSR_DATA_BITS'(tol_ff) : '0;

   // flow control
   logic [DEPTH-1:0] vld_ff;
   logic             en;

   assign en         = !vld_ff[DEPTH-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_tvalid};
      end
   end

   // unpack and vertex line
   logic signed [C-1:0]  vin    [2][3][3];
   logic signed [C-1:0]  vtx_ff [7][2][3][3];

   always_comb begin
      for (int k = 0; k < 2; k++)
         for (int i = 0; i < 3; i++)
            for (int c = 0; c < 3; c++)
               vin[k][i][c] = req_tdata[(k*3+i)*FIELD_BITS + c*C +: C];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vtx_ff[0] <= vin;
         for (int s = 1; s < 7; s++) vtx_ff[s] <= vtx_ff[s-1];
      end
   end

   // edges, plane offsets, normals
   logic signed [EW-1:0]  e1_ff  [2][3];
   logic signed [EW-1:0]  e2_ff  [2][3];
   logic signed [EW-1:0]  dlt_ff [3][2][3][3];
   logic signed [PEW-1:0] np_ff  [2][3][2];
   logic signed [NW-1:0]  nrm_ff [2][3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 2; k++) begin
            for (int c = 0; c < 3; c++) begin
               e1_ff[k][c] <= EW'(vtx_ff[0][k][0][c]) - EW'(vtx_ff[0][k][2][c]);
               e2_ff[k][c] <= EW'(vtx_ff[0][k][1][c]) - EW'(vtx_ff[0][k][2][c]);
               np_ff[k][c][0] <= e1_ff[k][nxt(c)] * e2_ff[k][prv(c)];
               np_ff[k][c][1] <= e1_ff[k][prv(c)] * e2_ff[k][nxt(c)];
               nrm_ff[k][c] <= NW'(np_ff[k][c][0]) - NW'(np_ff[k][c][1]);
               for (int i = 0; i < 3; i++) begin
                  dlt_ff[0][k][i][c] <= EW'(vtx_ff[0][k][i][c]) - EW'(vtx_ff[0][1-k][0][c]);
               end
            end
         end
         dlt_ff[1] <= dlt_ff[0];
         dlt_ff[2] <= dlt_ff[1];
      end
   end

   // line direction and side values
   logic signed [2*NW-1:0]  rdp [3][2];
   logic signed [NW+EW-1:0] sdp [2][3][3];
   logic signed [RW-1:0]    rd_ff [3];
   logic signed [SW-1:0]    sd_ff [2][3];

   for (genvar c = 0; c < 3; c++) begin : g_rd
      tpit_mul #(.AW(NW), .BW(NW)) u_rd0 (
         .clock(clock), .en(en),
         .a(nrm_ff[0][nxt(c)]), .b(nrm_ff[1][prv(c)]), .prod(rdp[c][0])
      );
      tpit_mul #(.AW(NW), .BW(NW)) u_rd1 (
         .clock(clock), .en(en),
         .a(nrm_ff[0][prv(c)]), .b(nrm_ff[1][nxt(c)]), .prod(rdp[c][1])
      );
   end

   for (genvar k = 0; k < 2; k++) begin : g_sdk
      for (genvar i = 0; i < 3; i++) begin : g_sdi
         for (genvar c = 0; c < 3; c++) begin : g_sdc
            tpit_mul #(.AW(NW), .BW(EW)) u_sd (
               .clock(clock), .en(en),
               .a(nrm_ff[1-k][c]), .b(dlt_ff[2][k][i][c]), .prod(sdp[k][i][c])
            );
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 3; c++) rd_ff[c] <= RW'(rdp[c][0]) - RW'(rdp[c][1]);
         for (int k = 0; k < 2; k++)
            for (int i = 0; i < 3; i++)
               sd_ff[k][i] <= SW'(sdp[k][i][0]) + SW'(sdp[k][i][1]) + SW'(sdp[k][i][2]);
      end
   end

   // projections onto the line
   logic signed [RW+C-1:0] xpp [2][3][3];
   logic signed [XW-1:0]   xp_ff [2][3];

   for (genvar k = 0; k < 2; k++) begin : g_xpk
      for (genvar i = 0; i < 3; i++) begin : g_xpi
         for (genvar c = 0; c < 3; c++) begin : g_xpc
            tpit_mul #(.AW(RW), .BW(C)) u_xp (
               .clock(clock), .en(en),
               .a(rd_ff[c]), .b(vtx_ff[6][k][i][c]), .prod(xpp[k][i][c])
            );
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 2; k++)
            for (int i = 0; i < 3; i++)
               xp_ff[k][i] <= XW'(xpp[k][i][0]) + XW'(xpp[k][i][1]) + XW'(xpp[k][i][2]);
      end
   end

   // side masks, lone vertex, fraction operands
   cls_type cls_in;
   cls_type cls_ff [3];

   always_comb begin
      logic [1:0]           ln;
      logic signed [DW-1:0] sl;
      logic signed [DW-1:0] df;
      cls_in = '0;
      for (int k = 0; k < 2; k++) begin
         for (int i = 0; i < 3; i++) begin
            cls_in.below[k][i] = sd_ff[k][i] < 0;
            cls_in.above[k][i] = sd_ff[k][i] > 0;
         end
         if (cls_in.above[k] == 3'b001 || cls_in.below[k] == 3'b001) ln = 2'd0;
         else if (cls_in.above[k] == 3'b010 || cls_in.below[k] == 3'b010) ln = 2'd1;
         else ln = 2'd2;
         cls_in.lone[k] = ln;
         sl = DW'(sd_ff[k][ln]);
         cls_in.rem[k] = (sl < 0) ? -sl : sl;
         for (int j = 0; j < 2; j++) begin
            df = sl - DW'(sd_ff[k][oth_of(ln, j[0])]);
            cls_in.den[2*k+j] = (df < 0) ? -df : df;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cls_ff[0] <= cls_in;
         cls_ff[1] <= cls_ff[0];
         cls_ff[2] <= cls_ff[1];
      end
   end

   // crossing fractions
   side_type        side_in;
   side_type        side_d;
   logic [DW-1:0]   div_num [LANES];
   logic [DW-1:0]   div_den [LANES];
   logic [QW-1:0]   thq     [LANES];
   logic [$bits(side_type)-1:0] side_raw;

   always_comb begin
      logic [1:0]           ln;
      logic signed [XW-1:0] xl;
      side_in.below = cls_ff[2].below;
      side_in.above = cls_ff[2].above;
      side_in.lone  = cls_ff[2].lone;
      for (int k = 0; k < 2; k++) begin
         ln = cls_ff[2].lone[k];
         xl = xp_ff[k][ln];
         side_in.xpl[k] = xl;
         for (int j = 0; j < 2; j++) begin
            side_in.xdiff[2*k+j] = XD'(xp_ff[k][oth_of(ln, j[0])]) - XD'(xl);
            div_num[2*k+j] = cls_ff[2].rem[k];
            div_den[2*k+j] = cls_ff[2].den[2*k+j];
         end
      end
   end

   tpit_div #(.DW(DW), .QW(QW), .PW($bits(side_type))) u_div (
      .clock(clock), .en(en),
      .num(div_num), .den(div_den), .pay_src(side_in),
      .quo(thq), .pay_dst(side_raw)
   );

   assign side_d = side_type'(side_raw);

   // crossing points on the line
   logic signed [QW+XD:0] tpp [LANES];
   side_type              side_ff [3];
   logic [QW-1:0]         thq_ff  [3][LANES];
   logic signed [TW-1:0]  tp_ff   [LANES];

   for (genvar l = 0; l < LANES; l++) begin : g_tp
      tpit_mul #(.AW(QW+1), .BW(XD)) u_tp (
         .clock(clock), .en(en),
         .a($signed({1'b0, thq[l]})), .b($signed(side_d.xdiff[l])), .prod(tpp[l])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_d;
         side_ff[1] <= side_ff[0];
         side_ff[2] <= side_ff[1];
         thq_ff[0]  <= thq;
         thq_ff[1]  <= thq_ff[0];
         thq_ff[2]  <= thq_ff[1];
         for (int l = 0; l < LANES; l++) begin
            tp_ff[l] <= (TW'($signed(side_ff[1].xpl[l>>1])) <<< FRAC_BITS) + TW'(tpp[l]);
         end
      end
   end

   // snap, intervals, verdict
   logic                 ok_in;
   logic signed [TW-1:0] lo_in [2];
   logic signed [TW-1:0] hi_in [2];
   logic                 ok_ff;
   logic signed [TW-1:0] lo_ff [2];
   logic signed [TW-1:0] hi_ff [2];
   logic                 crs_ff;

   always_comb begin
      logic [SNW-1:0] tl;
      logic [SNW-1:0] one;
      logic [SNW-1:0] gap;
      logic [SNW-1:0] tq;
      logic [2:0]     bl;
      logic [2:0]     ab;
      logic [1:0]     ln;
      logic           lowcut;
      tl    = SNW'(tol_ff) << FRAC_BITS;
      one   = SNW'(1) << FRAC_BITS;
      gap   = '0;
      tq    = '0;
      ok_in = 1'b1;
      for (int k = 0; k < 2; k++) begin
         bl = side_ff[2].below[k];
         ab = side_ff[2].above[k];
         ln = side_ff[2].lone[k];
         lowcut = ((SNW'(thq_ff[2][2*k]) << TOL_BITS) < tl) ||
                  ((SNW'(thq_ff[2][2*k+1]) << TOL_BITS) < tl);
         if (tol_ff != '0) begin
            if (lowcut) begin
               bl[ln] = 1'b0;
               ab[ln] = 1'b0;
            end else begin
               for (int j = 0; j < 2; j++) begin
                  tq  = SNW'(thq_ff[2][2*k+j]);
                  gap = (tq >= one) ? '0 : one - tq;
                  if ((gap << TOL_BITS) < tl) begin
                     bl[oth_of(ln, j[0])] = 1'b0;
                     ab[oth_of(ln, j[0])] = 1'b0;
                  end
               end
            end
         end
         ok_in = ok_in && (bl != '0) && (ab != '0);
         lo_in[k] = (tp_ff[2*k] < tp_ff[2*k+1]) ? tp_ff[2*k] : tp_ff[2*k+1];
         hi_in[k] = (tp_ff[2*k] > tp_ff[2*k+1]) ? tp_ff[2*k] : tp_ff[2*k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ok_ff  <= ok_in;
         lo_ff  <= lo_in;
         hi_ff  <= hi_in;
         crs_ff <= ok_ff && (lo_ff[0] < hi_ff[1]) && (lo_ff[1] < hi_ff[0]);
      end
   end

   assign rsp_tdata = RSP_DATA_BITS'(crs_ff);

   // checks
   logic thq_over;
   logic side_live;

   always_comb begin
      thq_over = 1'b0;
      for (int l = 0; l < LANES; l++) begin
         if (thq[l] > (QW'(1) << FRAC_BITS)) thq_over = 1'b1;
      end
   end

   assign side_live = (side_d.below[0] != '0) && (side_d.above[0] != '0) &&
                      (side_d.below[1] != '0) && (side_d.above[1] != '0);

   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while result stalled");

   a_entry_valid: assert property (@(posedge clock) disable iff (reset)
      en |=> vld_ff[0] == $past(req_tvalid))
      else $error("entry valid does not follow accepted beat");

   a_fraction_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[10+FRAC_BITS] && side_live |-> !thq_over)
      else $error("crossing fraction above one");

endmodule
